>>> hw/rtl/sss_pkg.sv
package sss_pkg;

  localparam int BYTE_W       = 8;
  localparam int NEEDLE_BYTES = 16;
  localparam int NLEN_W       = 5;
  localparam int STRIDE_W     = 16;
  localparam int FOUND_W      = 33;
  localparam int OUT_DATA_W   = 40;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 5;

  typedef logic [NEEDLE_BYTES-1:0][BYTE_W-1:0] needle_t;

  // Register index, taken from paddr[4:3].
  typedef enum logic [1:0] {
    REG_NEEDLE_LO  = 2'd0,
    REG_NEEDLE_HI  = 2'd1,
    REG_NEEDLE_LEN = 2'd2,
    REG_STRIDE     = 2'd3
  } cfg_reg_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
    logic load_flag;
  } cell_ctl_t;

  // Per-cell compare results.
  typedef struct packed {
    logic eq_ok;
    logic start_ok;
  } cell_stat_t;

  // Flag rewrite request from the phase unit.
  typedef struct packed {
    logic en;
    logic flag;
  } walk_t;

endpackage

>>> hw/rtl/sss_cell.sv
module sss_cell #(
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sss_pkg::cell_ctl_t              ctl,
  input  logic [sss_pkg::BYTE_W-1:0]      byte_in,
  input  logic                            flag_in,
  input  sss_pkg::needle_t                needle,
  input  logic [sss_pkg::NLEN_W-1:0]      n_used,
  output logic [sss_pkg::BYTE_W-1:0]      byte_out,
  output logic                            flag_out,
  output sss_pkg::cell_stat_t             stat
);

  logic [sss_pkg::BYTE_W-1:0] byte_r;
  logic                       flag_r;
  logic                       in_use;
  logic [sss_pkg::NLEN_W-1:0] rel;
  logic [sss_pkg::BYTE_W-1:0] expected;

  // The flag marks a byte whose position is a multiple of the step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
      flag_r <= 1'b0;
    end else begin
      priority if (ctl.clear) begin
        byte_r <= '0;
        flag_r <= 1'b0;
      end else if (ctl.shift) begin
        byte_r <= byte_in;
        flag_r <= flag_in;
      end else if (ctl.load) begin
        flag_r <= ctl.load_flag;
      end
    end
  end

  // Compare the byte this cell holds after the shift with its needle byte.
  always_comb begin
    in_use   = (IDX < int'(n_used));
    rel      = sss_pkg::NLEN_W'(n_used - sss_pkg::NLEN_W'(IDX + 1));
    expected = (rel < sss_pkg::NLEN_W'(sss_pkg::NEEDLE_BYTES)) ? needle[rel[3:0]] : '0;
    stat.eq_ok    = !in_use || (byte_in == expected);
    stat.start_ok = (int'(n_used) == IDX + 1) && flag_in;
  end

  assign byte_out = byte_r;
  assign flag_out = flag_r;

endmodule

>>> hw/rtl/sss_phase.sv
module sss_phase #(
  parameter int COUNT_BITS = 32,
  parameter int MAX_NEEDLE = 16,
  parameter int IDX_W      = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [sss_pkg::STRIDE_W-1:0]    step_i,
  input  logic [COUNT_BITS-1:0]           count_i,
  input  logic                            advance_i,
  input  logic                            clear_i,
  input  logic                            start_i,
  output logic                            busy_o,
  output logic                            head_flag_o,
  output sss_pkg::walk_t                  walk_o,
  output logic [IDX_W-1:0]                walk_idx_o
);

  localparam int SW    = sss_pkg::STRIDE_W;
  localparam int CNT_W = $clog2(COUNT_BITS);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DIV  = 3'b010,
    PH_WALK = 3'b100
  } ph_state_t;

  ph_state_t               state_r, state_nxt;
  logic [SW-1:0]           phase_r, phase_nxt;
  logic [SW-1:0]           rem_r, rem_nxt;
  logic [COUNT_BITS-1:0]   src_r, src_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [SW-1:0]           wph_r, wph_nxt;
  logic [IDX_W-1:0]        widx_r, widx_nxt;

  logic [SW:0]   rem2;
  logic [SW-1:0] rem_step;
  logic [SW:0]   inc;
  logic [SW-1:0] wdec;

  always_comb begin
    // One quotient bit per cycle, most significant bit of the count first.
    rem2     = {rem_r, src_r[COUNT_BITS-1]};
    rem_step = (rem2 >= {1'b0, step_i}) ? SW'(rem2 - {1'b0, step_i}) : rem2[SW-1:0];
    inc      = {1'b0, phase_r} + (SW+1)'(1);
    wdec     = (wph_r == '0) ? SW'(step_i - SW'(1)) : SW'(wph_r - SW'(1));

    state_nxt = state_r;
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    src_nxt   = src_r;
    cnt_nxt   = cnt_r;
    wph_nxt   = wph_r;
    widx_nxt  = widx_r;
    walk_o    = '0;

    if (start_i) begin
      state_nxt = PH_DIV;
      rem_nxt   = '0;
      src_nxt   = count_i;
      cnt_nxt   = '0;
    end else begin
      unique case (state_r)
        PH_IDLE: begin
          if (clear_i) begin
            phase_nxt = '0;
          end else if (advance_i) begin
            phase_nxt = (inc == {1'b0, step_i}) ? '0 : inc[SW-1:0];
          end
        end
        PH_DIV: begin
          rem_nxt = rem_step;
          src_nxt = {src_r[COUNT_BITS-2:0], 1'b0};
          cnt_nxt = CNT_W'(cnt_r + CNT_W'(1));
          if (cnt_r == CNT_W'(COUNT_BITS - 1)) begin
            state_nxt = PH_WALK;
            phase_nxt = rem_step;
            wph_nxt   = rem_step;
            widx_nxt  = '0;
          end
        end
        PH_WALK: begin
          // Cell k holds the byte at position count - 1 - k.
          walk_o.en   = 1'b1;
          walk_o.flag = (wdec == '0);
          wph_nxt     = wdec;
          widx_nxt    = IDX_W'(widx_r + IDX_W'(1));
          if (widx_r == IDX_W'(MAX_NEEDLE - 1)) begin
            state_nxt = PH_IDLE;
          end
        end
        default: begin
          state_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_IDLE;
      phase_r <= '0;
      cnt_r   <= '0;
      widx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      widx_r  <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    src_r <= src_nxt;
    wph_r <= wph_nxt;
  end

  assign busy_o      = (state_r != PH_IDLE);
  assign head_flag_o = (phase_r == '0);
  assign walk_idx_o  = widx_r;

endmodule

>>> hw/rtl/strided_substring_search_unit.sv
// The result of a beat marked last is registered in the output register or skid entry.
// One haystack beat per cycle while in_tready is high; the window compare is a fixed row
// of cells. A stride write stalls the input while the phase unit divides the byte count by
// the new step (one bit per cycle) and rewrites the cell flags.
// Reset is synchronous, active low: registers take 0, 0, 0, 1 and the search state clears.
module strided_substring_search_unit #(
  parameter int MAX_NEEDLE = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Haystack beats.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // haystack_byte
  input  logic                                in_tlast,   // last
  input  logic                                in_tuser,   // no_data
  // Search results.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sss_pkg::OUT_DATA_W-1:0]      out_tdata,  // found_at [32:0], zero fill
  // Configuration.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [sss_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [sss_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [sss_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int FW    = (COUNT_BITS + 1 > 33) ? COUNT_BITS + 1 : 33;
  localparam int SW    = sss_pkg::STRIDE_W;
  localparam int NW    = sss_pkg::NLEN_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // ---------------------------------------------------------------------------
  // Configuration registers. The register index is taken from paddr[4:3].
  // ---------------------------------------------------------------------------
  logic [63:0]   needle_lo_r;
  logic [63:0]   needle_hi_r;
  logic [NW-1:0] needle_len_r;
  logic [SW-1:0] stride_r;
  logic          cfg_wr;
  sss_pkg::cfg_reg_t cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = sss_pkg::cfg_reg_t'(cfg_paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_lo_r  <= '0;
      needle_hi_r  <= '0;
      needle_len_r <= '0;
      stride_r     <= SW'(1);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        sss_pkg::REG_NEEDLE_LO:  needle_lo_r  <= cfg_pwdata;
        sss_pkg::REG_NEEDLE_HI:  needle_hi_r  <= cfg_pwdata;
        sss_pkg::REG_NEEDLE_LEN: needle_len_r <= cfg_pwdata[NW-1:0];
        sss_pkg::REG_STRIDE:     stride_r     <= cfg_pwdata[SW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      sss_pkg::REG_NEEDLE_LO:  cfg_prdata = needle_lo_r;
      sss_pkg::REG_NEEDLE_HI:  cfg_prdata = needle_hi_r;
      sss_pkg::REG_NEEDLE_LEN: cfg_prdata = sss_pkg::CFG_DATA_W'(needle_len_r);
      sss_pkg::REG_STRIDE:     cfg_prdata = sss_pkg::CFG_DATA_W'(stride_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // Effective needle length and candidate step. A zero stride spaces
  // candidates by one, while the tail check still uses the raw value.
  sss_pkg::needle_t needle;
  logic [NW-1:0]    n_used;
  logic [SW-1:0]    step;

  assign needle = {needle_hi_r, needle_lo_r};
  assign n_used = (int'(needle_len_r) > MAX_NEEDLE) ? NW'(MAX_NEEDLE) : needle_len_r;
  assign step   = (stride_r == '0) ? SW'(1) : stride_r;

  // ---------------------------------------------------------------------------
  // Beat acceptance. The phase unit blocks input while it rebuilds, and the
  // two-entry output stage keeps ready independent of out_tready.
  // ---------------------------------------------------------------------------
  logic                  phase_busy;
  logic                  skid_valid_r;
  logic                  in_acc;
  logic                  take_byte;
  logic                  end_beat;
  logic [COUNT_BITS-1:0] bytes_seen_r;

  assign in_tready = !phase_busy && !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign take_byte = in_acc && !in_tuser && (bytes_seen_r != COUNT_MAX);
  assign end_beat  = in_acc && in_tlast;

  // ---------------------------------------------------------------------------
  // Phase unit: tracks the next position modulo the step, and after a stride
  // write recomputes it and the per-cell candidate flags.
  // ---------------------------------------------------------------------------
  logic              head_flag;
  sss_pkg::walk_t    walk;
  logic [IDX_W-1:0]  walk_idx;

  sss_phase #(
    .COUNT_BITS (COUNT_BITS),
    .MAX_NEEDLE (MAX_NEEDLE),
    .IDX_W      (IDX_W)
  ) u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (step),
    .count_i     (bytes_seen_r),
    .advance_i   (take_byte),
    .clear_i     (end_beat),
    .start_i     (cfg_wr && (cfg_sel == sss_pkg::REG_STRIDE)),
    .busy_o      (phase_busy),
    .head_flag_o (head_flag),
    .walk_o      (walk),
    .walk_idx_o  (walk_idx)
  );

  // ---------------------------------------------------------------------------
  // Window: a row of cells, each holding one byte and its candidate flag.
  // Cell 0 takes the newest byte; every byte taken (not no_data, count not saturated) moves the row by one.
  // ---------------------------------------------------------------------------
  logic [MAX_NEEDLE-1:0][sss_pkg::BYTE_W-1:0] byte_q;
  logic [MAX_NEEDLE-1:0]                      flag_q;
  logic [MAX_NEEDLE-1:0]                      eq_vec;
  logic [MAX_NEEDLE-1:0]                      start_vec;

  for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
    sss_pkg::cell_ctl_t         ctl;
    sss_pkg::cell_stat_t        stat;
    logic [sss_pkg::BYTE_W-1:0] b_in;
    logic                       f_in;

    if (k == 0) begin : g_head
      assign b_in = in_tdata;
      assign f_in = head_flag;
    end else begin : g_body
      assign b_in = byte_q[k-1];
      assign f_in = flag_q[k-1];
    end

    assign ctl.shift     = take_byte;
    assign ctl.clear     = end_beat;
    assign ctl.load      = walk.en && (walk_idx == IDX_W'(k));
    assign ctl.load_flag = walk.flag;

    sss_cell #(
      .IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .byte_in  (b_in),
      .flag_in  (f_in),
      .needle   (needle),
      .n_used   (n_used),
      .byte_out (byte_q[k]),
      .flag_out (flag_q[k]),
      .stat     (stat)
    );

    assign eq_vec[k]    = stat.eq_ok;
    assign start_vec[k] = stat.start_ok;
  end

  // ---------------------------------------------------------------------------
  // Match tracking. A candidate starts at count - n; its flag sits in cell
  // n - 1 after the shift.
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] first_match_r, first_match_nxt;
  logic                  match_seen_r, match_seen_nxt;
  logic [COUNT_BITS-1:0] bytes_seen_nxt;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] cand_pos;
  logic                  match_now;

  assign count     = COUNT_BITS'(bytes_seen_r + COUNT_BITS'(1));
  assign cand_pos  = COUNT_BITS'(count - COUNT_BITS'(n_used));
  assign match_now = take_byte && (n_used != '0) && (count >= COUNT_BITS'(n_used)) &&
                     !match_seen_r && (|start_vec) && (&eq_vec);

  // Result of a beat marked last, from the state after this beat's byte.
  logic [COUNT_BITS-1:0] len;
  logic [COUNT_BITS-1:0] tail;
  logic [COUNT_BITS-1:0] first;
  logic                  hit;
  logic [FW-1:0]         found_wide;
  logic [sss_pkg::FOUND_W-1:0] found;

  always_comb begin
    len   = take_byte ? count : bytes_seen_r;
    tail  = COUNT_BITS'(len - first_match_r);
    first = match_now ? cand_pos : first_match_r;
    if (match_now) begin
      // The match ends at the current byte, so the tail equals the length.
      hit = (SW'(n_used) >= stride_r);
    end else begin
      hit = match_seen_r && (CMP_W'(tail) >= CMP_W'(stride_r));
    end
    found_wide = FW'(first) + FW'(1);
    if (n_used == '0) begin
      // An empty needle matches at the start of a nonempty haystack whose length reaches the stride.
      found = ((len != '0) && (CMP_W'(len) >= CMP_W'(stride_r))) ?
              sss_pkg::FOUND_W'(1) : '0;
    end else begin
      found = hit ? found_wide[sss_pkg::FOUND_W-1:0] : '0;
    end
  end

  always_comb begin
    bytes_seen_nxt  = bytes_seen_r;
    first_match_nxt = first_match_r;
    match_seen_nxt  = match_seen_r;
    if (end_beat) begin
      bytes_seen_nxt  = '0;
      first_match_nxt = '0;
      match_seen_nxt  = 1'b0;
    end else begin
      if (take_byte) begin
        bytes_seen_nxt = count;
      end
      if (match_now) begin
        first_match_nxt = cand_pos;
        match_seen_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r  <= '0;
      first_match_r <= '0;
      match_seen_r  <= 1'b0;
    end else begin
      bytes_seen_r  <= bytes_seen_nxt;
      first_match_r <= first_match_nxt;
      match_seen_r  <= match_seen_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: the output register plus one skid entry. A new beat is
  // taken only while the skid entry is free, so a result always has a place.
  // ---------------------------------------------------------------------------
  logic                        out_valid_r;
  logic [sss_pkg::FOUND_W-1:0] out_data_r;
  logic [sss_pkg::FOUND_W-1:0] skid_data_r;
  logic                        out_pop;

  assign out_pop = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_pop) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= end_beat;
        end else begin
          out_valid_r  <= end_beat;
        end
      end else if (end_beat) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_pop) begin
      if (skid_valid_r) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= found;
      end else begin
        out_data_r  <= found;
      end
    end else if (end_beat) begin
      skid_data_r <= found;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = sss_pkg::OUT_DATA_W'(out_data_r);

endmodule
